[hw/rtl/iobt_pkg.sv]
// Package for the interval booking table: sizes, status codes and entry type.
`default_nettype none

package iobt_pkg;

    // Number of table entries (cells in the chain)
    localparam int MAX_BOOKINGS = 64;
    localparam int CNT_W        = $clog2(MAX_BOOKINGS + 1);
    localparam int TIME_W       = 32;

    // Result codes
    typedef enum logic [1:0] {
        ST_BOOKED  = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // One half-open interval with its precomputed non-empty flag
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic              nonempty;
    } t_entry;

endpackage

`default_nettype wire

[hw/rtl/iobt_if.sv]
// Valid/ready channel interfaces for booking requests and responses.
`default_nettype none

interface iobt_req_if
    import iobt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;

    modport source (output valid, output start_time, output end_time, input ready);
    modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

interface iobt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/iobt_cell.sv]
// One table cell: holds an interval, checks it against the request, shifts on insert.
`default_nettype none

module iobt_cell
    import iobt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_shift,
    input  wire t_entry i_entry,
    output t_entry      o_entry,
    input  wire logic   i_valid,
    input  wire t_entry i_req,
    output logic        o_hit
);

    t_entry r_entry;
    logic   r_hit;

    // Take the neighbor's entry when a new interval is pushed into the chain
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    // Overlap: both non-empty and each start lies below the other's end
    always_ff @(posedge i_clk) begin
        r_hit <= i_valid && r_entry.nonempty && i_req.nonempty
                 && (r_entry.start_time < i_req.end_time)
                 && (i_req.start_time < r_entry.end_time);
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

[hw/rtl/interval_overlap_booking_table.sv]
// Interval booking table: overlap check against a chain of stored intervals.
//
// Requests arrive on i_req (start_time, end_time: half-open [start, end)).
// Each request gives exactly one response on o_rsp with a status:
// booked and stored, refused for overlap, or refused because the table is full.
// Every stored interval sits in one cell of a chain of MAX_BOOKINGS cells;
// a booked interval enters cell 0 and all occupied cells move one place on.
// Timing: the request is registered at acceptance, all cells compare it in
// the next cycle, and the decide state that follows, once the output can take
// a response, reduces the hits, pushes the entry and loads the response
// register. A new request is accepted in the decide cycle of the previous
// one, so the block takes the next request while it decides the last one.
// If the receiver stalls, a finished response waits in the output register and
// the next request still runs up to its decide cycle, where it waits.
// Reset empties the table (entry count zero) and drops any pending response.
`default_nettype none

module interval_overlap_booking_table
    import iobt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    iobt_req_if.sink    i_req,
    iobt_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DECIDE
    } t_state;

    t_state            r_state;
    t_entry            r_req;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    t_status           r_status;

    t_entry            w_chain [MAX_BOOKINGS];
    logic [MAX_BOOKINGS-1:0] w_hit;
    logic              w_can_emit;
    logic              w_any_hit;
    logic              w_full;
    logic              w_decide;
    logic              w_book;
    logic              w_accept;

    // Decide and handshake logic
    always_comb begin
        w_can_emit = !r_out_valid || o_rsp.ready;
        w_any_hit  = |w_hit;
        w_full     = (r_count == CNT_W'(MAX_BOOKINGS));
        w_decide   = (r_state == S_DECIDE) && w_can_emit;
        w_book     = w_decide && !w_any_hit && !w_full;
        i_req.ready = (r_state == S_IDLE) || w_decide;
        w_accept   = i_req.valid && i_req.ready;
    end

    // State, request register, entry count and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_req.start_time <= i_req.start_time;
                r_req.end_time   <= i_req.end_time;
                r_req.nonempty   <= (i_req.start_time < i_req.end_time);
            end
            if (w_decide) begin
                r_out_valid <= 1'b1;
                if (w_any_hit) begin
                    r_status <= ST_OVERLAP;
                end else if (w_full) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_BOOKED;
                end
            end
            if (w_book) begin
                r_count <= r_count + CNT_W'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (w_decide) begin
                        r_state <= w_accept ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Chain of cells; cell 0 takes the new request on insert
    for (genvar g = 0; g < MAX_BOOKINGS; g++) begin : g_cell
        t_entry w_in;
        logic   w_valid;

        if (g == 0) begin : g_head
            assign w_in = r_req;
        end else begin : g_link
            assign w_in = w_chain[g-1];
        end

        assign w_valid = (r_count > CNT_W'(g));

        iobt_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_book),
            .i_entry (w_in),
            .o_entry (w_chain[g]),
            .i_valid (w_valid),
            .i_req   (r_req),
            .o_hit   (w_hit[g])
        );
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_status;

endmodule

`default_nettype wire
